// ----- rtl/ilins_pkg.sv -----
// Package for the indexed list insert unit: widths, status codes, control structs.
`timescale 1ns / 1ps

package ilins_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int POS_W        = 6;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction, idx <= count
    logic set_bad;    // prepare invalid-position response
    logic set_full;   // prepare list-full response
    logic shift_rd;   // read entry idx-1
    logic shift_wr;   // write read data to entry idx, idx--
    logic write_new;  // write new value at pos, count++
    logic emit_rd;    // read entry for next result, step the walk
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad_pos;
    logic full;
    logic at_pos;
    logic next_at_pos;
    logic out_last;
  } dp_stat_t;

endpackage

// ----- rtl/indexed_list_insert_unit.sv -----
// Top level of the indexed list insert unit.
`timescale 1ns / 1ps

// Keeps an ordered list of up to CAPACITY signed 32-bit values in a RAM. Each
// input transaction inserts value_i at position_i (0 = front, count = end) and
// then streams the whole list front to back (reverse_o = 0) and back to front
// (reverse_o = 1), with last_o on the final result. A position beyond the
// count gives a single result with status 1; a full list gives status 2; in
// both cases nothing changes. One item is handled at a time: the unit accepts
// it, checks it, moves each entry back (RAM read, then write, since the RAM
// has registered reads), writes the new value and starts the readout, then
// gives one result per cycle while out_stall_i is low. The list is empty after
// reset; no clearing pass is needed.

module indexed_list_insert_unit
  import ilins_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [VAL_W-1:0] item_value_o,
  output logic                    reverse_o,
  output logic [STATUS_W-1:0]     status_o,
  output logic                    last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ilins_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  ilins_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .position_i  (position_i),
    .value_i     (value_i),
    .item_value_o(item_value_o),
    .reverse_o   (reverse_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ----- rtl/ilins_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ilins_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/ilins_dp.sv -----
// Datapath: list storage, entry count, walk index and result registers.
`timescale 1ns / 1ps

module ilins_dp
  import ilins_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  output dp_stat_t                   stat_o,
  input  logic [POS_W-1:0]           position_i,
  input  logic signed [VAL_W-1:0]    value_i,
  output logic signed [VAL_W-1:0]    item_value_o,
  output logic                       reverse_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic                       last_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic                rev_q, rev_d;
  logic [POS_W-1:0]    pos_q;
  logic [VAL_W-1:0]    val_q;
  logic                out_rev_q, out_last_q;
  logic [STATUS_W-1:0] out_status_q;

  logic [CW-1:0]       idx_m1, cnt_m1;
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [VAL_W-1:0]    ram_wdata, ram_rdata;

  assign idx_m1 = idx_q - 1'b1;
  assign cnt_m1 = count_q - 1'b1;

  assign ram_re    = cmd_i.shift_rd | cmd_i.emit_rd;
  assign ram_raddr = cmd_i.shift_rd ? idx_m1[AW-1:0] : idx_q[AW-1:0];
  assign ram_we    = cmd_i.shift_wr | cmd_i.write_new;
  assign ram_waddr = cmd_i.shift_wr ? idx_q[AW-1:0] : pos_q[AW-1:0];
  assign ram_wdata = cmd_i.shift_wr ? ram_rdata : val_q;

  ilins_ram #(
    .WIDTH(VAL_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_we),
    .wr_addr_i(ram_waddr),
    .wr_data_i(ram_wdata),
    .rd_en_i  (ram_re),
    .rd_addr_i(ram_raddr),
    .rd_data_o(ram_rdata)
  );

  always_comb begin
    count_d = count_q;
    idx_d   = idx_q;
    rev_d   = rev_q;
    if (cmd_i.load) begin
      idx_d = count_q;
    end
    if (cmd_i.shift_wr) begin
      idx_d = idx_m1;
    end
    if (cmd_i.write_new) begin
      count_d = count_q + 1'b1;
      idx_d   = '0;
      rev_d   = 1'b0;
    end
    if (cmd_i.emit_rd) begin
      // forward walk 0..n-1, then backward n-1..0
      if (!rev_q) begin
        if (idx_q == cnt_m1) begin
          rev_d = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end else if (idx_q != '0) begin
        idx_d = idx_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      rev_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      rev_q   <= rev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (cmd_i.set_bad || cmd_i.set_full) begin
      out_status_q <= cmd_i.set_bad ? ST_BADPOS : ST_FULL;
      out_rev_q    <= 1'b0;
      out_last_q   <= 1'b1;
    end else if (cmd_i.emit_rd) begin
      out_status_q <= ST_OK;
      out_rev_q    <= rev_q;
      out_last_q   <= rev_q && (idx_q == '0);
    end
  end

  assign stat_o.bad_pos     = pos_q > POS_W'(count_q);
  assign stat_o.full        = count_q == CW'(CAPACITY);
  assign stat_o.at_pos      = POS_W'(idx_q) == pos_q;
  assign stat_o.next_at_pos = POS_W'(idx_m1) == pos_q;
  assign stat_o.out_last    = out_last_q;

  assign item_value_o = (out_status_q == ST_OK) ? ram_rdata : '0;
  assign reverse_o    = out_rev_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.write_new |=> count_q == CW'($past(count_q) + 1'b1))
    else $error("insert did not advance entry count");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.shift_wr |-> POS_W'(idx_q) > pos_q)
    else $error("shift wrote at or below the insert position");

endmodule

// ----- rtl/ilins_ctrl.sv -----
// Controller: sequences check, shift, insert and result emission.
`timescale 1ns / 1ps

module ilins_ctrl
  import ilins_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_SHIFT_RD = 3'd2;
  localparam logic [2:0] S_SHIFT_WR = 3'd3;
  localparam logic [2:0] S_WRITE    = 3'd4;
  localparam logic [2:0] S_EMIT0    = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;
  localparam logic [2:0] S_RESP     = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        // position check comes before the full check
        if (stat_i.bad_pos) begin
          cmd_o.set_bad = 1'b1;
          state_d       = S_RESP;
        end else if (stat_i.full) begin
          cmd_o.set_full = 1'b1;
          state_d        = S_RESP;
        end else if (stat_i.at_pos) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        cmd_o.shift_rd = 1'b1;
        state_d        = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = stat_i.next_at_pos ? S_WRITE : S_SHIFT_RD;
      end
      S_WRITE: begin
        cmd_o.write_new = 1'b1;
        state_d         = S_EMIT0;
      end
      S_EMIT0: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        // read of the next entry overlaps the transaction of this one
        if (!out_stall_i) begin
          if (stat_i.out_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.emit_rd = 1'b1;
          end
        end
      end
      S_RESP: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = (state_q == S_OUT) || (state_q == S_RESP);

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && stat_i.out_last |=> state_q == S_IDLE)
    else $error("final result did not end the item");

  a_resp_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP |-> stat_i.out_last)
    else $error("error response not marked last");

  a_no_emit_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !cmd_o.emit_rd)
    else $error("result data advanced while stalled");

endmodule

// ----- test/tb_top.sv -----
// Testbench for indexed_list_insert_unit: directed and random inserts checked against a list model.
`timescale 1ns / 1ps

module tb_top;
  import ilins_pkg::*;

  localparam int CAP        = CAPACITY_DEF;
  localparam int HALF_CLK   = 6;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 265;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    reverse;
    logic [STATUS_W-1:0]     status;
    logic                    last;
  } list_result_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  logic [POS_W-1:0]        position_i  = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] item_value_o;
  logic                    reverse_o;
  logic [STATUS_W-1:0]     status_o;
  logic                    last_o;

  // model state
  logic signed [VAL_W-1:0] model_list [CAP];
  int unsigned             model_count = 0;
  list_result_t            pending_results [$];

  int    fail_count  = 0;
  int    idle_cycles = 0;
  int    stall_left  = 0;
  int    stall_roll;
  bit    no_idle     = 1'b0;
  list_result_t exp_res;

  indexed_list_insert_unit u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .item_value_o (item_value_o),
    .reverse_o    (reverse_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always #HALF_CLK clk_i = ~clk_i;

  task automatic report_mismatch(input string field, input logic [VAL_W-1:0] exp_v,
                                 input logic [VAL_W-1:0] got_v);
    $display("[%0t] mismatch on %s: expected %h, got %h", $time, field, exp_v, got_v);
    fail_count++;
  endtask

  // Append one expected result at the tail of the queue.
  task automatic queue_result(input list_result_t res);
    pending_results = {pending_results, res};
  endtask

  // Insert into the model list and queue the readout the block must produce.
  task automatic apply_insert(input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
    list_result_t res;
    int unsigned  p;
    p = pos;
    if (p > model_count) begin
      res = '{value: '0, reverse: 1'b0, status: ST_BADPOS, last: 1'b1};
      queue_result(res);
    end else if (model_count >= CAP) begin
      res = '{value: '0, reverse: 1'b0, status: ST_FULL, last: 1'b1};
      queue_result(res);
    end else begin
      for (int unsigned i = model_count; i > p; i--) model_list[i] = model_list[i-1];
      model_list[p] = val;
      model_count++;
      for (int unsigned i = 0; i < model_count; i++) begin
        res = '{value: model_list[i], reverse: 1'b0, status: ST_OK, last: 1'b0};
        queue_result(res);
      end
      for (int unsigned i = model_count; i > 0; i--) begin
        res = '{value: model_list[i-1], reverse: 1'b1, status: ST_OK, last: (i == 1)};
        queue_result(res);
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return {1'b1, {(VAL_W-1){1'b0}}};
    if (r < 16) return {1'b0, {(VAL_W-1){1'b1}}};
    if (r < 20) return '0;
    if (r < 24) return '1;
    return $urandom;
  endfunction

  // One input transaction; returns at the edge where it is accepted.
  task automatic send_insert(input logic [POS_W-1:0] pos, input logic signed [VAL_W-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_i <= pos;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_insert(pos, val);
  endtask

  task automatic wait_all_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_insert(6'd1, 32'sd5);
    send_insert(6'd63, -32'sd1);
    send_insert(6'd33, 32'sd7);
  endtask

  task automatic test_edge_inserts();
    send_insert(6'd0, {1'b1, {(VAL_W-1){1'b0}}});
    send_insert(6'd1, {1'b0, {(VAL_W-1){1'b1}}});
    send_insert(6'd0, -32'sd1);
    send_insert(6'd1, 32'sd0);
    send_insert(6'd2, 32'sd1234);
    send_insert(6'd6, 32'sd99);                 // one past the end
    send_insert(6'd5, 32'sh5555_5555);
    send_insert(6'd3, 32'shAAAA_AAAA);
    // let the whole readout drain before sending more
    wait_all_results();
  endtask

  task automatic test_fill_random();
    int n;
    n = 0;
    while (model_count < CAP) begin
      if ((n % 20) == 10) no_idle = ~no_idle;
      if ($urandom_range(0, 99) < 85)
        send_insert(POS_W'($urandom_range(0, model_count)), pick_value());
      else
        send_insert(POS_W'($urandom_range(model_count + 1, 63)), pick_value());
      n++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_list();
    send_insert(6'd32, 32'sd1);
    send_insert(6'd0, -32'sd2);
    send_insert(6'd33, 32'sd3);
    send_insert(6'd63, 32'sd4);
  endtask

  task automatic test_random_full();
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if ((n % 40) == 20) no_idle = ~no_idle;
      if (n == RAND_ITEMS / 2) wait_all_results();
      send_insert(POS_W'($urandom_range(0, 63)), pick_value());
    end
    no_idle = 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, item_value_o);
      end else begin
        exp_res = pending_results.pop_front();
        if (item_value_o !== exp_res.value)
          report_mismatch("item_value", exp_res.value, item_value_o);
        if (reverse_o !== exp_res.reverse)
          report_mismatch("reverse", VAL_W'(exp_res.reverse), VAL_W'(reverse_o));
        if (status_o !== exp_res.status)
          report_mismatch("status", VAL_W'(exp_res.status), VAL_W'(status_o));
        if (last_o !== exp_res.last)
          report_mismatch("last", VAL_W'(exp_res.last), VAL_W'(last_o));
      end
    end
  end

  // receiver backpressure: mostly short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (no_idle) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall_i <= 1'b1;
      end else begin
        stall_left = $urandom_range(6, 30);
        out_stall_i <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edge_inserts();
    test_fill_random();
    test_full_list();
    test_random_full();
    wait_all_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
